/* rtl/core/rws_pkg.sv */
// Shared constants, codes and word types of the roulette wheel selector.
package rws_pkg;

  localparam int RWS_MAX_MEMBERS  = 256;
  localparam int RWS_WEIGHT_WIDTH = 32;
  localparam int RWS_DRAW_WIDTH   = 40;
  localparam int RWS_POP_WIDTH    = 9;
  localparam logic [RWS_POP_WIDTH-1:0] RWS_POP_RESET = 9'd256;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_SUM  = 2'd1;
  localparam logic [1:0] STATUS_DRAW_HIGH = 2'd2;

  // Input word modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_MINIMIZE = 1'b0;
  localparam logic REG_POP      = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [7:0]                entry_index;
    logic [31:0]               weight_value;
    logic [RWS_DRAW_WIDTH-1:0] draw_value;
  } rws_req_t;

  typedef struct packed {
    logic [7:0] selected_index;
    logic [1:0] status;
  } rws_rsp_t;

endpackage

/* rtl/core/rws_stream_if.sv */
// Valid/ready stream channel carrying one payload word.
interface rws_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/roulette_wheel_selector.sv */
// Roulette wheel selector: top level with control, configuration and the cell row.
//
// Usage:
//   req is a valid/ready stream of rws_req_t words. A word with mode load
//   writes weight_value (kept to WEIGHT_WIDTH bits) into entry entry_index;
//   indexes at or above MAX_MEMBERS are dropped. A word with mode select
//   starts one selection with draw_value and later gives one rsp word.
//   rsp is a valid/ready stream of rws_rsp_t words (index and status).
//   The APB port holds minimize_mode (0x0) and population_count (0x4);
//   write them only while the block is idle.
// Operation:
//   A load is written into its cell as it is taken. A select sends a
//   token down the row of MAX_MEMBERS cells twice, once to find the
//   largest weight and once to walk the running sum against the draw.
//   The next word is taken no earlier than the cycle in which the result
//   becomes valid; the cell row is the only path and holds one selection
//   at a time.
// Reset and stall:
//   Reset clears the control state and registers (minimize off, count 256);
//   weights are undefined until loaded. A finished result waits in the
//   output register while rsp stalls, and new words are still accepted;
//   a second result waits in a pending register until the first is taken.
module roulette_wheel_selector
  import rws_pkg::*;
#(
  parameter int MAX_MEMBERS  = RWS_MAX_MEMBERS,
  parameter int WEIGHT_WIDTH = RWS_WEIGHT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  rws_stream_if.sink   req,
  rws_stream_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(MAX_MEMBERS);
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam int RUN_W = WEIGHT_WIDTH + IDX_W + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAX   = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  typedef struct packed {
    logic                    go;
    logic                    walk;
    logic                    found;
    logic [CNT_W-1:0]        left;
    logic [IDX_W-1:0]        pos;
    logic [IDX_W-1:0]        pick;
    logic [WEIGHT_WIDTH-1:0] maxw;
    logic [RUN_W-1:0]        run;
  } tok_t;

  logic [1:0]               state;
  logic                     minimize;
  logic [RWS_POP_WIDTH-1:0] pop;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [RWS_DRAW_WIDTH-1:0] draw;
  tok_t                     head;
  tok_t                     head_next;
  tok_t                     chain [0:MAX_MEMBERS];
  tok_t                     tail;
  logic [MAX_MEMBERS-1:0]   we;
  logic [MAX_MEMBERS-1:0]   go_vec;
  logic [WEIGHT_WIDTH-1:0]  wdata;
  logic                     req_acc;
  logic                     load_acc;
  logic                     sel_acc;
  logic                     cfg_wr;
  logic                     out_valid;
  rws_rsp_t                 out_word;
  rws_rsp_t                 pend_word;
  rws_rsp_t                 fin_word;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimize <= 1'b0;
      pop      <= RWS_POP_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MINIMIZE: minimize <= pwdata[0];
        REG_POP:      pop      <= pwdata[RWS_POP_WIDTH-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MINIMIZE: prdata = {31'd0, minimize};
      REG_POP:      prdata = 32'(pop);
      default:      prdata = '0;
    endcase
  end

  // ---------------- input acceptance ----------------
  // Take words only between selections; loads finish in the cycle they land.
  assign req.ready = (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign load_acc  = req_acc && (req.data.mode == MODE_LOAD);
  assign sel_acc   = req_acc && (req.data.mode == MODE_SELECT);
  assign wdata     = WEIGHT_WIDTH'(req.data.weight_value);

  // Clamp the member count to the size of the row
  assign count_next = (32'(pop) > MAX_MEMBERS) ? CNT_W'(MAX_MEMBERS) : CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < MAX_MEMBERS; i++) begin
      we[i] = load_acc && (32'(req.data.entry_index) == i);
    end
  end

  // ---------------- cell row ----------------
  assign chain[0] = head;
  assign tail     = chain[MAX_MEMBERS];

  for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_cell
    rws_cell #(
      .MAX_MEMBERS  (MAX_MEMBERS),
      .WEIGHT_WIDTH (WEIGHT_WIDTH),
      .DRAW_WIDTH   (RWS_DRAW_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .we       (we[g]),
      .wdata    (wdata),
      .minimize (minimize),
      .draw     (draw),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
    assign go_vec[g] = chain[g+1].go;
  end

  // Classify the walk token: no hit means the draw reached the total
  always_comb begin
    fin_word = '0;
    if (tail.found) begin
      fin_word.selected_index = 8'(tail.pick);
      fin_word.status         = STATUS_OK;
    end else if (tail.run == '0) begin
      fin_word.status = STATUS_ZERO_SUM;
    end else begin
      fin_word.status = STATUS_DRAW_HIGH;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    head_next = '0;
    if (sel_acc) begin
      // Launch the max-finding token
      head_next.go   = 1'b1;
      head_next.left = count_next;
    end else if (state == ST_MAX && tail.go) begin
      // Relaunch with the maximum for the walk
      head_next.go   = 1'b1;
      head_next.walk = 1'b1;
      head_next.left = count;
      head_next.maxw = tail.maxw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_acc) begin
      count <= count_next;
      draw  <= req.data.draw_value;
    end
    if (state == ST_WALK && tail.go) begin
      pend_word <= fin_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sel_acc) begin
            state <= ST_MAX;
          end
        end
        ST_MAX: begin
          if (tail.go) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (tail.go) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_valid || rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WAIT && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT && (!out_valid || rsp.ready)) begin
      out_word <= pend_word;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  // ---------------- assertions ----------------
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(go_vec))
    else $error("more than one token in the cell row");

  a_tail_in_pass: assert property (@(posedge clk) disable iff (rst)
    tail.go |-> (state == ST_MAX || state == ST_WALK))
    else $error("token left the row outside a selection");

  a_walk_follows_max: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAX && tail.go) |=> (head.go && head.walk))
    else $error("walk token not launched after max pass");

  a_err_index_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.status != STATUS_OK) |-> (rsp.data.selected_index == 8'd0))
    else $error("error result carries a nonzero index");

  a_wait_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && (!out_valid || rsp.ready)) |=> (out_valid && state == ST_IDLE))
    else $error("pending result not moved to output");

endmodule

/* rtl/core/rws_cell.sv */
// One wheel cell: holds a weight and updates the token passing through it.
module rws_cell #(
  parameter int MAX_MEMBERS  = 256,
  parameter int WEIGHT_WIDTH = 32,
  parameter int DRAW_WIDTH   = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    we,
  input  logic [WEIGHT_WIDTH-1:0] wdata,
  input  logic                    minimize,
  input  logic [DRAW_WIDTH-1:0]   draw,
  input  logic [$clog2(MAX_MEMBERS+1)+2*$clog2(MAX_MEMBERS)+2*WEIGHT_WIDTH+$clog2(MAX_MEMBERS)+3:0]
                                  tok_in,
  output logic [$clog2(MAX_MEMBERS+1)+2*$clog2(MAX_MEMBERS)+2*WEIGHT_WIDTH+$clog2(MAX_MEMBERS)+3:0]
                                  tok_out
);

  localparam int IDX_W = $clog2(MAX_MEMBERS);
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam int RUN_W = WEIGHT_WIDTH + IDX_W + 1;
  localparam int CMP_W = (RUN_W > DRAW_WIDTH) ? RUN_W : DRAW_WIDTH;

  typedef struct packed {
    logic                    go;
    logic                    walk;
    logic                    found;
    logic [CNT_W-1:0]        left;
    logic [IDX_W-1:0]        pos;
    logic [IDX_W-1:0]        pick;
    logic [WEIGHT_WIDTH-1:0] maxw;
    logic [RUN_W-1:0]        run;
  } tok_t;

  logic [WEIGHT_WIDTH-1:0] weight;
  logic [WEIGHT_WIDTH:0]   eff;
  logic [RUN_W-1:0]        run_sum;
  logic                    hit;
  logic                    takes;
  tok_t                    tin;
  tok_t                    tok_next;
  tok_t                    tok;

  assign tin     = tok_in;
  assign tok_out = tok;

  always_ff @(posedge clk) begin
    if (we) begin
      weight <= wdata;
    end
  end

  always_comb begin
    // Inverted weight for minimize mode: max - w + 1
    if (minimize) begin
      eff = {1'b0, tin.maxw} - {1'b0, weight} + {{WEIGHT_WIDTH{1'b0}}, 1'b1};
    end else begin
      eff = {1'b0, weight};
    end
    run_sum = tin.run + RUN_W'(eff);
    hit     = CMP_W'(run_sum) > CMP_W'(draw);
    takes   = tin.go && (tin.left != '0);

    tok_next     = tin;
    tok_next.pos = tin.pos + 1'b1;
    if (takes) begin
      tok_next.left = tin.left - 1'b1;
      if (!tin.walk) begin
        if (weight > tin.maxw) begin
          tok_next.maxw = weight;
        end
      end else if (!tin.found) begin
        tok_next.run = run_sum;
        if (hit) begin
          tok_next.found = 1'b1;
          tok_next.pick  = tin.pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

endmodule

/* bench/testbench.sv */
// Self-checking bench for the roulette wheel selector: weight loads, picks and register settings.
`timescale 1ns / 1ps

module testbench;
  import rws_pkg::*;

  // Longest a pick can still be running once the last result is out, plus margin
  localparam int DRAIN_CYCLES = 2 * RWS_MAX_MEMBERS + 16;
  // Receiver hold-off long enough for the output and pending results to pile up and stall the input
  localparam int LONG_HOLD    = 4000;

  typedef enum logic [1:0] {STEP_REG, STEP_LOAD, STEP_PICK} step_kind_e;

  // One row of the directed table: a register write, a weight load or a pick
  typedef struct {
    step_kind_e                kind;
    logic                      reg_sel;
    logic [31:0]               value;
    logic [7:0]                index;
    logic [RWS_DRAW_WIDTH-1:0] draw;
    bit                        typed;
    rws_rsp_t                  want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rws_stream_if #(.payload_t(rws_req_t)) req_ch ();
  rws_stream_if #(.payload_t(rws_rsp_t)) rsp_ch ();

  roulette_wheel_selector uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the weight table and the registers, advanced as words are accepted
  logic [RWS_WEIGHT_WIDTH-1:0] weight_copy [RWS_MAX_MEMBERS];
  logic                        minimize_copy;
  logic [RWS_POP_WIDTH-1:0]    count_copy;

  rws_rsp_t pick_q [$];     // picks owed by the block, oldest first
  step_t    script_q [$];   // directed table
  int       errors      = 0;
  bit       burst_on    = 1'b0;
  int       hold_cycles = 0;
  rws_rsp_t seen;
  rws_rsp_t owed;

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Wheel arithmetic on the shadow table
  // ---------------------------------------------------------------------------

  // Counts above the table size act as the full table
  function automatic int live_members();
    return (count_copy > RWS_MAX_MEMBERS) ? RWS_MAX_MEMBERS : int'(count_copy);
  endfunction

  function automatic logic [RWS_WEIGHT_WIDTH-1:0] heaviest();
    logic [RWS_WEIGHT_WIDTH-1:0] top;
    top = '0;
    for (int i = 0; i < live_members(); i++)
      if (weight_copy[i] > top) top = weight_copy[i];
    return top;
  endfunction

  // Width of one slice of the wheel; minimize flips it to top - w + 1
  function automatic logic [63:0] slice_width(int i, logic [RWS_WEIGHT_WIDTH-1:0] top);
    if (minimize_copy) return 64'(top) - 64'(weight_copy[i]) + 64'd1;
    return 64'(weight_copy[i]);
  endfunction

  // Sum of the first upto slices; with upto = live_members() this is the wheel total
  function automatic logic [63:0] wheel_span(int upto);
    logic [RWS_WEIGHT_WIDTH-1:0] top;
    logic [63:0]                 sum;
    top = heaviest();
    sum = '0;
    for (int i = 0; i < upto; i++) sum += slice_width(i, top);
    return sum;
  endfunction

  // Advance the shadow by one accepted word and work out the pick it owes, if any
  task automatic predict_pick(input rws_req_t w, output bit has, output rws_rsp_t r);
    int                          n;
    logic [63:0]                 total;
    logic [63:0]                 run;
    logic [RWS_WEIGHT_WIDTH-1:0] top;
    has = 1'b0;
    r   = '0;
    if (w.mode == MODE_LOAD) begin
      weight_copy[w.entry_index] = w.weight_value;
    end else begin
      has   = 1'b1;
      n     = live_members();
      top   = heaviest();
      total = wheel_span(n);
      if (total == 0) begin
        r.status = STATUS_ZERO_SUM;
      end else if (64'(w.draw_value) >= total) begin
        r.status = STATUS_DRAW_HIGH;
      end else begin
        r.status = STATUS_OK;
        run = '0;
        // First member whose running sum passes the draw wins
        for (int i = 0; i < n; i++) begin
          run += slice_width(i, top);
          if (run > 64'(w.draw_value)) begin
            r.selected_index = 8'(i);
            break;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  // Mix zeros, the top value, small weights and full-range ones
  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return 32'hFFFF_FFFF;
      2, 3, 4, 5: return 32'($urandom_range(1, 15));
      6, 7:       return $urandom();
      default:    return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // Mostly land inside the wheel, often right on a slice boundary, sometimes past it
  function automatic logic [RWS_DRAW_WIDTH-1:0] pick_draw();
    int          n;
    logic [63:0] total;
    logic [63:0] bound;
    logic [63:0] wide;
    n     = live_members();
    total = wheel_span(n);
    wide  = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (total != 0) wide = wide % total;
      end
      6, 7: begin
        if (n > 0) begin
          bound = wheel_span($urandom_range(1, n));
          wide  = (bound != 0) ? bound - 64'($urandom_range(0, 1)) : 64'd0;
        end
      end
      8:       wide = total - 64'($urandom_range(0, 1));
      default: ;
    endcase
    return wide[RWS_DRAW_WIDTH-1:0];
  endfunction

  function automatic rws_req_t random_word();
    rws_req_t w;
    int       n;
    n = live_members();
    w.mode        = ($urandom_range(0, 99) < 45) ? MODE_LOAD : MODE_SELECT;
    w.entry_index = 8'($urandom());
    // Keep most loads inside the live part of the wheel so they change picks
    if (w.mode == MODE_LOAD && n > 0 && $urandom_range(0, 9) < 7)
      w.entry_index = 8'($urandom_range(0, n - 1));
    w.weight_value = pick_weight();
    w.draw_value   = {8'($urandom()), 32'($urandom())};
    if (w.mode == MODE_SELECT) w.draw_value = pick_draw();
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------

  function automatic void put_reg(logic sel, logic [31:0] value);
    step_t s;
    s         = '{kind: STEP_REG, default: '0};
    s.reg_sel = sel;
    s.value   = value;
    script_q.insert(script_q.size(), s);
  endfunction

  function automatic void put_load(logic [7:0] index, logic [31:0] weight);
    step_t s;
    s       = '{kind: STEP_LOAD, default: '0};
    s.index = index;
    s.value = weight;
    s.draw  = {8'($urandom()), 32'($urandom())};
    script_q.insert(script_q.size(), s);
  endfunction

  // typed set: the pick is read straight off the row instead of the predictor
  function automatic void put_pick(logic [RWS_DRAW_WIDTH-1:0] draw, bit typed,
                                   logic [7:0] idx, logic [1:0] status);
    step_t s;
    s                     = '{kind: STEP_PICK, default: '0};
    s.index               = 8'($urandom());
    s.value               = $urandom();
    s.draw                = draw;
    s.typed               = typed;
    s.want.selected_index = idx;
    s.want.status         = status;
    script_q.insert(script_q.size(), s);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one word after a random gap (none in burst mode), hold it until taken, then predict
  task automatic send_word(input rws_req_t w, input bit typed, input rws_rsp_t want);
    int       gap;
    bit       has;
    rws_rsp_t r;
    gap = burst_on ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    do @(posedge clk); while (!req_ch.ready);
    predict_pick(w, has, r);
    if (has) pick_q.insert(pick_q.size(), typed ? want : r);
  endtask

  // Drop valid, wait for every owed pick, then let any trailing load finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pick_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write a register over APB, read it back, and update the shadow
  task automatic write_reg(input logic sel, input logic [31:0] value);
    logic [31:0] mask;
    mask = (sel == REG_MINIMIZE) ? 32'h1 : 32'h1FF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Register took the value at this edge; start the read-back setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask))
      report_mismatch($sformatf("register %0d read back %0h, wrote %0h",
                                sel, prdata & mask, value & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_MINIMIZE) minimize_copy = value[0];
    else count_copy = value[RWS_POP_WIDTH-1:0];
  endtask

  // One random phase under a fixed register setting
  task automatic run_phase(input logic mode_bit, input logic [RWS_POP_WIDTH-1:0] count,
                           input int items, input bit burst, input bit hold);
    settle();
    write_reg(REG_MINIMIZE, 32'(mode_bit));
    write_reg(REG_POP, 32'(count));
    burst_on = burst;
    if (hold) hold_cycles = LONG_HOLD;
    for (int k = 0; k < items; k++) send_word(random_word(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at random per word, or hold off for a long stretch on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = burst_on ? 0 : $urandom_range(0, 7);
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each taken result with the oldest owed pick
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen = rsp_ch.data;
      if (pick_q.size() == 0) begin
        report_mismatch($sformatf("result index %0d status %0d with none owed",
                                  seen.selected_index, seen.status));
      end else begin
        owed = pick_q.pop_front();
        if (seen.selected_index !== owed.selected_index)
          report_mismatch($sformatf("selected_index %0d, owed %0d",
                                    seen.selected_index, owed.selected_index));
        if (seen.status !== owed.status)
          report_mismatch($sformatf("status %0d, owed %0d", seen.status, owed.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rws_req_t w;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    foreach (weight_copy[i]) weight_copy[i] = '0;
    minimize_copy = 1'b0;
    count_copy    = RWS_POP_RESET;

    // Directed table. Shrink the wheel to four members so every entry read is loaded.
    put_reg(REG_POP, 32'd4);
    put_load(8'd0, 32'd0);
    put_load(8'd1, 32'd0);
    put_load(8'd2, 32'd0);
    put_load(8'd3, 32'd0);
    // All-zero wheel in maximize mode has nothing to land on
    put_pick(40'd0, 1'b1, 8'd0, STATUS_ZERO_SUM);
    // Wheel becomes {0, 5, 0, max}: zero slices are never picked
    put_load(8'd1, 32'd5);
    put_load(8'd3, 32'hFFFF_FFFF);
    put_pick(40'd0, 1'b1, 8'd1, STATUS_OK);
    put_pick(40'd4, 1'b1, 8'd1, STATUS_OK);
    put_pick(40'd5, 1'b1, 8'd3, STATUS_OK);
    put_pick(40'h1_0000_0003, 1'b1, 8'd3, STATUS_OK);
    // Draw equal to the total, and the largest draw, both miss the wheel
    put_pick(40'h1_0000_0004, 1'b1, 8'd0, STATUS_DRAW_HIGH);
    put_pick(40'hFF_FFFF_FFFF, 1'b1, 8'd0, STATUS_DRAW_HIGH);
    // Top entry lies outside the live wheel and must not disturb it
    put_load(8'd255, 32'hFFFF_FFFF);
    put_load(8'd0, 32'd1);
    put_pick(40'd0, 1'b1, 8'd0, STATUS_OK);
    put_pick(40'd1, 1'b1, 8'd1, STATUS_OK);
    put_pick(40'h0_8000_0000, 1'b0, 8'd0, STATUS_OK);
    // Minimize: slices turn into max - w + 1, so the heaviest entry gets width one
    put_reg(REG_MINIMIZE, 32'd1);
    put_pick(40'd0, 1'b0, 8'd0, STATUS_OK);
    put_pick(40'h1_FFFF_FFF9, 1'b0, 8'd0, STATUS_OK);
    put_pick(40'h2_FFFF_FFFA, 1'b0, 8'd0, STATUS_OK);
    put_pick(40'hFF_FFFF_FFFF, 1'b1, 8'd0, STATUS_DRAW_HIGH);
    // Empty wheel gives a zero total in either mode
    put_reg(REG_POP, 32'd0);
    put_pick(40'd0, 1'b1, 8'd0, STATUS_ZERO_SUM);
    put_reg(REG_MINIMIZE, 32'd0);
    put_pick(40'd0, 1'b1, 8'd0, STATUS_ZERO_SUM);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; register rows wait for the block to go idle first
    foreach (script_q[k]) begin
      if (script_q[k].kind == STEP_REG) begin
        settle();
        write_reg(script_q[k].reg_sel, script_q[k].value);
      end else begin
        w.mode         = (script_q[k].kind == STEP_LOAD) ? MODE_LOAD : MODE_SELECT;
        w.entry_index  = script_q[k].index;
        w.weight_value = script_q[k].value;
        w.draw_value   = script_q[k].draw;
        send_word(w, script_q[k].typed, script_q[k].want);
      end
    end

    // Load every entry once so any population count reads only written weights
    for (int i = 0; i < RWS_MAX_MEMBERS; i++) begin
      w.mode         = MODE_LOAD;
      w.entry_index  = 8'(i);
      w.weight_value = pick_weight();
      w.draw_value   = {8'($urandom()), 32'($urandom())};
      send_word(w, 1'b0, '0);
    end

    // Random phases over the register extremes and random counts; one holds the receiver off
    // long enough that the block backs up and stalls its input
    run_phase(1'b0, 9'd256, 125, 1'b0, 1'b0);
    run_phase(1'b1, 9'd256, 125, 1'b0, 1'b1);
    run_phase(1'b0, 9'd511, 125, 1'b1, 1'b0);
    run_phase(1'b1, 9'd1, 70, 1'b0, 1'b0);
    run_phase(1'b0, 9'd1, 70, 1'b0, 1'b0);
    run_phase(1'b0, 9'($urandom_range(2, 255)), 125, 1'b0, 1'b0);
    run_phase(1'b1, 9'($urandom_range(2, 255)), 125, 1'b1, 1'b0);
    run_phase(1'b1, 9'($urandom_range(257, 510)), 125, 1'b0, 1'b0);

    settle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rws_pkg.sv
rtl/core/rws_stream_if.sv
rtl/core/rws_cell.sv
rtl/core/roulette_wheel_selector.sv
bench/testbench.sv
